[src/uvr_pkg.sv]
// ============================================================================
// uvr_pkg
// Shared types and constants for the unicycle velocity rollout core.
// ============================================================================
package uvr_pkg;

    localparam int ADDR_W    = 5;
    localparam int CORDIC_MAX = 24;
    localparam int ITER_W    = 5;
    localparam int CW        = 34;

    localparam logic [2:0] REG_STEP_TIME   = 3'd0;
    localparam logic [2:0] REG_ACCEL       = 3'd1;
    localparam logic [2:0] REG_BRAKE       = 3'd2;
    localparam logic [2:0] REG_FORWARD     = 3'd3;
    localparam logic [2:0] REG_BACKWARD    = 3'd4;
    localparam logic [2:0] REG_TURN_ACCEL  = 3'd5;
    localparam logic [2:0] REG_TURN_LIMIT  = 3'd6;

    // Radians to binary angle, scaled by 2^44.
    localparam logic [29:0] HEAD_K  = 30'd683565276;
    localparam logic [14:0] HEAD_KH = HEAD_K[29:15];
    localparam logic [14:0] HEAD_KL = HEAD_K[14:0];

    localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;

    typedef struct packed {
        logic [15:0]        step_time;
        logic [14:0]        accel_limit;
        logic [14:0]        brake_limit;
        logic signed [15:0] forward_limit;
        logic signed [15:0] backward_limit;
        logic [14:0]        turn_accel_limit;
        logic [14:0]        turn_limit;
    } cfg_t;

    typedef struct packed {
        logic              load;
        logic              spd;
        logic              hmul;
        logic              hpart;
        logic              hadd;
        logic              cinit;
        logic              rot;
        logic              fold;
        logic              pmul;
        logic              done;
        logic [ITER_W-1:0] iter;
    } cmd_t;

    function automatic logic [31:0] atan_entry(input logic [ITER_W-1:0] idx);
        logic [31:0] r;
        begin
            case (idx)
                5'd0:    r = 32'h20000000;
                5'd1:    r = 32'h12E4051E;
                5'd2:    r = 32'h09FB385B;
                5'd3:    r = 32'h051111D4;
                5'd4:    r = 32'h028B0D43;
                5'd5:    r = 32'h0145D7E1;
                5'd6:    r = 32'h00A2F61E;
                5'd7:    r = 32'h00517C55;
                5'd8:    r = 32'h0028BE53;
                5'd9:    r = 32'h00145F2F;
                5'd10:   r = 32'h000A2F98;
                5'd11:   r = 32'h000517CC;
                5'd12:   r = 32'h00028BE6;
                5'd13:   r = 32'h000145F3;
                5'd14:   r = 32'h0000A2FA;
                5'd15:   r = 32'h0000517D;
                5'd16:   r = 32'h000028BE;
                5'd17:   r = 32'h0000145F;
                5'd18:   r = 32'h00000A30;
                5'd19:   r = 32'h00000518;
                5'd20:   r = 32'h0000028C;
                5'd21:   r = 32'h00000146;
                5'd22:   r = 32'h000000A3;
                5'd23:   r = 32'h00000051;
                default: r = 32'h00000000;
            endcase
            return r;
        end
    endfunction

endpackage

[src/uvr_ctrl.sv]
// ============================================================================
// uvr_ctrl
// Sequencer for one integration tick and owner of the result valid flag.
// ============================================================================
module uvr_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    output uvr_pkg::cmd_t cmd
);
    import uvr_pkg::*;

    localparam int EFF = (CORDIC_STEPS > CORDIC_MAX) ? CORDIC_MAX : CORDIC_STEPS;
    localparam int IW  = (EFF > 1) ? $clog2(EFF) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_SPD, S_HMUL, S_HPART, S_HADD, S_CINIT, S_ROT, S_FOLD, S_PMUL, S_DONE
    } state_t;

    state_t        state_reg, state_next;
    logic [IW-1:0] iter_reg, iter_next;
    logic          out_valid_reg, out_valid_next;
    logic          can_finish;

    assign can_finish = !out_valid_reg || !out_stall;
    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        cmd.iter   = ITER_W'(iter_reg);
        cmd.load   = (state_reg == S_IDLE) && in_valid;
        cmd.spd    = (state_reg == S_SPD);
        cmd.hmul   = (state_reg == S_HMUL);
        cmd.hpart  = (state_reg == S_HPART);
        cmd.hadd   = (state_reg == S_HADD);
        cmd.cinit  = (state_reg == S_CINIT);
        cmd.rot    = (state_reg == S_ROT);
        cmd.fold   = (state_reg == S_FOLD);
        cmd.pmul   = (state_reg == S_PMUL);
        cmd.done   = (state_reg == S_DONE) && can_finish;
    end

    always_comb
    begin
        state_next     = state_reg;
        iter_next      = iter_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_SPD;
            S_SPD:   state_next = S_HMUL;
            S_HMUL:  state_next = S_HPART;
            S_HPART: state_next = S_HADD;
            S_HADD:  state_next = S_CINIT;
            S_CINIT:
            begin
                iter_next  = '0;
                state_next = S_ROT;
            end
            S_ROT:
            begin
                iter_next = iter_reg + 1'b1;
                if (iter_reg == IW'(EFF - 1))
                begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD:  state_next = S_PMUL;
            S_PMUL:  state_next = S_DONE;
            S_DONE:
            begin
                if (can_finish)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[src/uvr_datapath.sv]
// ============================================================================
// uvr_datapath
// Speed limiting, heading integration, iterative CORDIC and pose update.
// ============================================================================
module uvr_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  uvr_pkg::cmd_t       cmd,
    input  uvr_pkg::cfg_t       cfg,
    input  logic                restart,
    input  logic signed [15:0]  start_speed,
    input  logic signed [15:0]  start_turn_rate,
    input  logic signed [15:0]  target_speed,
    input  logic signed [15:0]  target_turn_rate,
    output logic signed [15:0]  speed,
    output logic signed [15:0]  turn_rate,
    output logic signed [31:0]  pos_x,
    output logic signed [31:0]  pos_y,
    output logic [15:0]         heading
);
    import uvr_pkg::*;

    logic signed [15:0] cur_speed_reg, cur_turn_reg;
    logic [15:0]        cur_head_reg;
    logic signed [31:0] acc_x_reg, acc_y_reg;
    logic signed [15:0] tv_reg, tw_reg;
    logic [31:0]        hp_mag_reg;
    logic               hp_neg_reg;
    logic [46:0]        pk_hi_reg, pk_lo_reg;
    logic signed [CW-1:0] x_reg, y_reg, z_reg;
    logic               fold_neg_reg;
    logic [31:0]        dist_mag_reg;
    logic               dist_neg_reg;
    logic [16:0]        cmag_reg, smag_reg;
    logic               cneg_reg, sneg_reg;
    logic [48:0]        px_reg, py_reg;
    logic               pxn_reg, pyn_reg;
    logic signed [15:0] speed_reg, turn_rate_reg;
    logic signed [31:0] pos_x_reg, pos_y_reg;
    logic [15:0]        heading_reg;

    // Speed and turn-rate update.
    logic               lin_up, turn_up;
    logic [14:0]        lin_lim;
    logic [30:0]        lin_prod, turn_prod;
    logic [14:0]        dv, dw;
    logic signed [17:0] v18, tv18, up_v, dn_v, fwd18, bwd18, v_a, v_new;
    logic signed [17:0] w18, tw18, up_w, dn_w, tl18, ntl18, w_a, w_new;

    always_comb
    begin
        lin_up    = (tv_reg >= cur_speed_reg);
        turn_up   = (tw_reg >= cur_turn_reg);
        lin_lim   = lin_up ? cfg.accel_limit : cfg.brake_limit;
        lin_prod  = 31'(lin_lim) * 31'(cfg.step_time);
        turn_prod = 31'(cfg.turn_accel_limit) * 31'(cfg.step_time);
        dv        = lin_prod[30:16];
        dw        = turn_prod[30:16];
        v18   = 18'(cur_speed_reg);
        tv18  = 18'(tv_reg);
        fwd18 = 18'(cfg.forward_limit);
        bwd18 = 18'(cfg.backward_limit);
        up_v  = v18 + $signed({3'b000, dv});
        dn_v  = v18 - $signed({3'b000, dv});
        if (lin_up)
        begin
            v_a   = (up_v < tv18) ? up_v : tv18;
            v_new = (v_a < fwd18) ? v_a : fwd18;
        end
        else
        begin
            v_a   = (dn_v > tv18) ? dn_v : tv18;
            v_new = (v_a > bwd18) ? v_a : bwd18;
        end
        w18   = 18'(cur_turn_reg);
        tw18  = 18'(tw_reg);
        tl18  = $signed({3'b000, cfg.turn_limit});
        ntl18 = -tl18;
        up_w  = w18 + $signed({3'b000, dw});
        dn_w  = w18 - $signed({3'b000, dw});
        if (turn_up)
        begin
            w_a   = (up_w < tw18) ? up_w : tw18;
            w_new = (w_a < tl18) ? w_a : tl18;
        end
        else
        begin
            w_a   = (dn_w > tw18) ? dn_w : tw18;
            w_new = (w_a > ntl18) ? w_a : ntl18;
        end
    end

    // Magnitudes of speed and turn rate.
    logic [15:0] w_mag, v_mag;
    assign w_mag = cur_turn_reg[15] ? 16'(-cur_turn_reg) : 16'(cur_turn_reg);
    assign v_mag = cur_speed_reg[15] ? 16'(-cur_speed_reg) : 16'(cur_speed_reg);

    // Heading step rounding.
    logic [62:0] head_sum;
    logic [15:0] hd_mag, hd;
    always_comb
    begin
        head_sum = {1'b0, pk_hi_reg, 15'b0} + 63'(pk_lo_reg) + (63'(1) << 43);
        hd_mag   = head_sum[59:44];
        hd       = hp_neg_reg ? (16'd0 - hd_mag) : hd_mag;
    end

    // CORDIC folding into the right half plane.
    logic signed [15:0]   ang;
    logic signed [16:0]   ang_f;
    logic                 fold_neg;
    always_comb
    begin
        ang = $signed(cur_head_reg);
        if (ang > 16'sd16384)
        begin
            ang_f    = 17'(ang) - 17'sd32768;
            fold_neg = 1'b1;
        end
        else if (ang < -16'sd16384)
        begin
            ang_f    = 17'(ang) + 17'sd32768;
            fold_neg = 1'b1;
        end
        else
        begin
            ang_f    = 17'(ang);
            fold_neg = 1'b0;
        end
    end

    // One rotation step.
    logic signed [CW-1:0] xs, ys, at;
    always_comb
    begin
        xs = x_reg >>> cmd.iter;
        ys = y_reg >>> cmd.iter;
        at = $signed({2'b00, atan_entry(cmd.iter)});
    end

    // Rounding CORDIC results to Q2.14.
    logic signed [CW-1:0] xr, yr;
    logic signed [17:0]   cr, sr;
    always_comb
    begin
        xr = (x_reg + 34'sd32768) >>> 16;
        yr = (y_reg + 34'sd32768) >>> 16;
        cr = xr[17:0];
        sr = yr[17:0];
    end

    // Position update with saturation.
    logic [49:0]        rx_sum, ry_sum;
    logic signed [24:0] dx, dy;
    logic signed [33:0] nx, ny;
    logic signed [31:0] ax_new, ay_new;
    always_comb
    begin
        rx_sum = 50'(px_reg) + (50'(1) << 25);
        ry_sum = 50'(py_reg) + (50'(1) << 25);
        dx = pxn_reg ? -$signed({1'b0, rx_sum[49:26]}) : $signed({1'b0, rx_sum[49:26]});
        dy = pyn_reg ? -$signed({1'b0, ry_sum[49:26]}) : $signed({1'b0, ry_sum[49:26]});
        nx = 34'(acc_x_reg) + 34'(dx);
        ny = 34'(acc_y_reg) + 34'(dy);
        if (nx > 34'sd2147483647)
            ax_new = 32'sh7FFFFFFF;
        else if (nx < -34'sd2147483648)
            ax_new = 32'sh80000000;
        else
            ax_new = nx[31:0];
        if (ny > 34'sd2147483647)
            ay_new = 32'sh7FFFFFFF;
        else if (ny < -34'sd2147483648)
            ay_new = 32'sh80000000;
        else
            ay_new = ny[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_speed_reg <= '0;
            cur_turn_reg  <= '0;
            cur_head_reg  <= '0;
            acc_x_reg     <= '0;
            acc_y_reg     <= '0;
        end
        else
        begin
            if (cmd.load && restart)
            begin
                cur_speed_reg <= start_speed;
                cur_turn_reg  <= start_turn_rate;
                cur_head_reg  <= '0;
                acc_x_reg     <= '0;
                acc_y_reg     <= '0;
            end
            if (cmd.spd)
            begin
                cur_speed_reg <= v_new[15:0];
                cur_turn_reg  <= w_new[15:0];
            end
            if (cmd.hadd)
            begin
                cur_head_reg <= cur_head_reg + hd;
            end
            if (cmd.done)
            begin
                acc_x_reg <= ax_new;
                acc_y_reg <= ay_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            tv_reg <= target_speed;
            tw_reg <= target_turn_rate;
        end
        if (cmd.hmul)
        begin
            hp_mag_reg <= 32'(w_mag) * 32'(cfg.step_time);
            hp_neg_reg <= cur_turn_reg[15];
        end
        if (cmd.hpart)
        begin
            pk_hi_reg <= 47'(hp_mag_reg) * 47'(HEAD_KH);
            pk_lo_reg <= 47'(hp_mag_reg) * 47'(HEAD_KL);
        end
        if (cmd.cinit)
        begin
            x_reg        <= CORDIC_X0;
            y_reg        <= '0;
            z_reg        <= 34'(ang_f) <<< 16;
            fold_neg_reg <= fold_neg;
            dist_mag_reg <= 32'(v_mag) * 32'(cfg.step_time);
            dist_neg_reg <= cur_speed_reg[15];
        end
        if (cmd.rot)
        begin
            if (!z_reg[CW-1])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
        if (cmd.fold)
        begin
            cmag_reg <= cr[17] ? 17'(-cr) : cr[16:0];
            smag_reg <= sr[17] ? 17'(-sr) : sr[16:0];
            cneg_reg <= cr[17] ^ fold_neg_reg;
            sneg_reg <= sr[17] ^ fold_neg_reg;
        end
        if (cmd.pmul)
        begin
            px_reg  <= 49'(dist_mag_reg) * 49'(cmag_reg);
            py_reg  <= 49'(dist_mag_reg) * 49'(smag_reg);
            pxn_reg <= dist_neg_reg ^ cneg_reg;
            pyn_reg <= dist_neg_reg ^ sneg_reg;
        end
        if (cmd.done)
        begin
            speed_reg     <= cur_speed_reg;
            turn_rate_reg <= cur_turn_reg;
            heading_reg   <= cur_head_reg;
            pos_x_reg     <= ax_new;
            pos_y_reg     <= ay_new;
        end
    end

    assign speed     = speed_reg;
    assign turn_rate = turn_rate_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign heading   = heading_reg;

endmodule

[src/unicycle_velocity_rollout_core.sv]
// ============================================================================
// unicycle_velocity_rollout_core
// One Euler integration tick of a unicycle robot per input beat.
// ============================================================================
// Each input beat advances speed and turn rate toward their targets within
// the configured limits, integrates the heading and adds speed times tick
// times cos and sin of the new heading to a saturating local position. The
// single CORDIC rotation unit performs one step per cycle. A beat's result
// is valid after its speed, heading, CORDIC, fold, product and done states.
// A new beat is accepted in the cycle after the previous one has finished,
// even while its result still waits on the output, and not before.
// Registers are written over APB at byte address 4*i and should be changed
// only while the core is idle.
module unicycle_velocity_rollout_core #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [uvr_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          restart,
    input  logic signed [15:0]            start_speed,
    input  logic signed [15:0]            start_turn_rate,
    input  logic signed [15:0]            target_speed,
    input  logic signed [15:0]            target_turn_rate,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [15:0]            speed,
    output logic signed [15:0]            turn_rate,
    output logic signed [31:0]            pos_x,
    output logic signed [31:0]            pos_y,
    output logic [15:0]                   heading
);
    import uvr_pkg::*;

    cfg_t        cfg_reg;
    cmd_t        cmd;
    logic        wr_en;
    logic [2:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_time        <= 16'd6554;
            cfg_reg.accel_limit      <= 15'd4096;
            cfg_reg.brake_limit      <= 15'd4096;
            cfg_reg.forward_limit    <= 16'sd4096;
            cfg_reg.backward_limit   <= -16'sd2048;
            cfg_reg.turn_accel_limit <= 15'd4096;
            cfg_reg.turn_limit       <= 15'd4096;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_STEP_TIME:  cfg_reg.step_time        <= pwdata[15:0];
                REG_ACCEL:      cfg_reg.accel_limit      <= pwdata[14:0];
                REG_BRAKE:      cfg_reg.brake_limit      <= pwdata[14:0];
                REG_FORWARD:    cfg_reg.forward_limit    <= pwdata[15:0];
                REG_BACKWARD:   cfg_reg.backward_limit   <= pwdata[15:0];
                REG_TURN_ACCEL: cfg_reg.turn_accel_limit <= pwdata[14:0];
                REG_TURN_LIMIT: cfg_reg.turn_limit       <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_STEP_TIME:  prdata = 32'(cfg_reg.step_time);
            REG_ACCEL:      prdata = 32'(cfg_reg.accel_limit);
            REG_BRAKE:      prdata = 32'(cfg_reg.brake_limit);
            REG_FORWARD:    prdata = {16'b0, cfg_reg.forward_limit};
            REG_BACKWARD:   prdata = {16'b0, cfg_reg.backward_limit};
            REG_TURN_ACCEL: prdata = 32'(cfg_reg.turn_accel_limit);
            REG_TURN_LIMIT: prdata = 32'(cfg_reg.turn_limit);
            default:        prdata = 32'b0;
        endcase
    end

    uvr_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    uvr_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .cfg              (cfg_reg),
        .restart          (restart),
        .start_speed      (start_speed),
        .start_turn_rate  (start_turn_rate),
        .target_speed     (target_speed),
        .target_turn_rate (target_turn_rate),
        .speed            (speed),
        .turn_rate        (turn_rate),
        .pos_x            (pos_x),
        .pos_y            (pos_y),
        .heading          (heading)
    );

endmodule

[sim/tb_unicycle_velocity_rollout_core.sv]
// ============================================================================
// tb_unicycle_velocity_rollout_core
// Self-checking testbench for the unicycle velocity rollout core.
// ============================================================================
// Drives integration ticks through the valid/stall input channel, predicts
// speed, turn rate, heading and saturating pose for every accepted beat, and
// compares each output beat against the oldest prediction. Registers are
// programmed over APB between phases while the core is idle.
module tb_unicycle_velocity_rollout_core;
    import uvr_pkg::*;

    localparam int STEPS = 16;
    localparam int LATENCY = 40;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic signed [15:0] speed;
        logic signed [15:0] turn_rate;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [15:0]        heading;
    } pose_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic restart = 1'b0;
    logic signed [15:0] start_speed = '0;
    logic signed [15:0] start_turn_rate = '0;
    logic signed [15:0] target_speed = '0;
    logic signed [15:0] target_turn_rate = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [15:0] speed;
    logic signed [15:0] turn_rate;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0] heading;

    unicycle_velocity_rollout_core #(.CORDIC_STEPS(STEPS)) dut (.*);

    always #10 clk = ~clk;

    cfg_t cfg;
    logic signed [15:0] sp_st, tr_st;
    logic [15:0] hd_st;
    logic signed [31:0] x_st, y_st;
    pose_t pose_q[$];
    bit failed = 1'b0;
    int idle_cycles = 0;
    int burst_left = 0;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_away(longint v, int s);
        longint half;
        half = longint'(1) << (s - 1);
        if (v >= 0)
            return (v + half) >>> s;
        return -((-v + half) >>> s);
    endfunction

    function automatic logic signed [31:0] sat_add(logic signed [31:0] a, longint d);
        longint s;
        s = longint'(a) + d;
        if (s > 64'sd2147483647)
            s = 64'sd2147483647;
        if (s < -64'sd2147483648)
            s = -64'sd2147483648;
        return s[31:0];
    endfunction

    function automatic longint atan_turn(int i);
        longint t[24] = '{
            64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
            64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
            64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
            64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
            64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};
        return t[i];
    endfunction

    task automatic sin_cos(input logic [15:0] ang, output longint c14, output longint s14);
        longint a, x, y, z, nx;
        bit flip;
        a = longint'($signed(ang));
        flip = 1'b0;
        x = 652032874;
        y = 0;
        if (a > 16384)
        begin
            a -= 32768;
            flip = 1'b1;
        end
        else if (a < -16384)
        begin
            a += 32768;
            flip = 1'b1;
        end
        z = a * 65536;
        for (int i = 0; i < STEPS && i < 24; i++)
        begin
            if (z >= 0)
            begin
                nx = x - floor_shift(y, i);
                y = y + floor_shift(x, i);
                z -= atan_turn(i);
            end
            else
            begin
                nx = x + floor_shift(y, i);
                y = y - floor_shift(x, i);
                z += atan_turn(i);
            end
            x = nx;
        end
        x = floor_shift(x + 32768, 16);
        y = floor_shift(y + 32768, 16);
        c14 = flip ? -x : x;
        s14 = flip ? -y : y;
    endtask

    task automatic integrate_tick(input logic rs, input logic signed [15:0] ss,
                                  input logic signed [15:0] sw,
                                  input logic signed [15:0] tv,
                                  input logic signed [15:0] tw);
        longint dt, v, w, dv, dw, hd, travel, c14, s14, lim;
        pose_t p;
        dt = longint'(cfg.step_time);
        if (rs)
        begin
            sp_st = ss;
            tr_st = sw;
            hd_st = '0;
            x_st = '0;
            y_st = '0;
        end
        v = sp_st;
        w = tr_st;
        if (tv >= v)
        begin
            dv = (longint'(cfg.accel_limit) * dt) >>> 16;
            v = v + dv;
            if (tv < v) v = tv;
            if (cfg.forward_limit < v) v = cfg.forward_limit;
        end
        else
        begin
            dv = (longint'(cfg.brake_limit) * dt) >>> 16;
            v = v - dv;
            if (tv > v) v = tv;
            if (cfg.backward_limit > v) v = cfg.backward_limit;
        end
        dw = (longint'(cfg.turn_accel_limit) * dt) >>> 16;
        lim = longint'(cfg.turn_limit);
        if (tw >= w)
        begin
            w = w + dw;
            if (tw < w) w = tw;
            if (lim < w) w = lim;
        end
        else
        begin
            w = w - dw;
            if (tw > w) w = tw;
            if (-lim > w) w = -lim;
        end
        sp_st = v[15:0];
        tr_st = w[15:0];
        hd = round_away(w * dt * 683565276, 44);
        hd_st = hd_st + hd[15:0];
        sin_cos(hd_st, c14, s14);
        travel = v * dt;
        x_st = sat_add(x_st, round_away(travel * c14, 26));
        y_st = sat_add(y_st, round_away(travel * s14, 26));
        p.speed = sp_st;
        p.turn_rate = tr_st;
        p.pos_x = x_st;
        p.pos_y = y_st;
        p.heading = hd_st;
        pose_q.push_back(p);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = ADDR_W'(idx) << 2;
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            REG_STEP_TIME:  cfg.step_time = val[15:0];
            REG_ACCEL:      cfg.accel_limit = val[14:0];
            REG_BRAKE:      cfg.brake_limit = val[14:0];
            REG_FORWARD:    cfg.forward_limit = val[15:0];
            REG_BACKWARD:   cfg.backward_limit = val[15:0];
            REG_TURN_ACCEL: cfg.turn_accel_limit = val[14:0];
            REG_TURN_LIMIT: cfg.turn_limit = val[14:0];
            default: ;
        endcase
    endtask

    task automatic program_all(input logic [15:0] st, input logic [14:0] acc,
                               input logic [14:0] brk, input logic [15:0] fwd,
                               input logic [15:0] bwd, input logic [14:0] tacc,
                               input logic [14:0] tlim);
        write_reg(REG_STEP_TIME, {16'h0, st});
        write_reg(REG_ACCEL, {17'h0, acc});
        write_reg(REG_BRAKE, {17'h0, brk});
        write_reg(REG_FORWARD, {16'h0, fwd});
        write_reg(REG_BACKWARD, {16'h0, bwd});
        write_reg(REG_TURN_ACCEL, {17'h0, tacc});
        write_reg(REG_TURN_LIMIT, {17'h0, tlim});
    endtask

    task automatic send_tick(input logic rs, input logic [15:0] ss, input logic [15:0] sw,
                             input logic [15:0] tv, input logic [15:0] tw);
        if (burst_left == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 40) : 0)
                @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_valid = 1'b1;
        restart = rs;
        start_speed = ss;
        start_turn_rate = sw;
        target_speed = tv;
        target_turn_rate = tw;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        integrate_tick(rs, ss, sw, tv, tw);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic drain;
        while (pose_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_speed();
        case ($urandom_range(0, 4))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic random_ticks(input int count);
        for (int i = 0; i < count; i++)
            send_tick($urandom_range(0, 15) == 0, rand_speed(), rand_speed(),
                      rand_speed(), rand_speed());
    endtask

    task automatic test_directed_reset_values;
        send_tick(1'b0, 16'h0, 16'h0, 16'h1000, 16'h1000);
        send_tick(1'b1, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF);
        send_tick(1'b1, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000);
        send_tick(1'b0, 16'h0, 16'h0, 16'h0, 16'h0);
        send_tick(1'b1, 16'h0, 16'h0, 16'hF000, 16'h0800);
        for (int i = 0; i < 6; i++)
            send_tick(1'b0, 16'hFFFF, 16'hFFFF, 16'h1000, 16'hF000);
        drain();
    endtask

    task automatic test_zero_tick_and_crossed_limits;
        program_all(16'h0, 15'h7FFF, 15'h7FFF, 16'h8000, 16'h7FFF, 15'h7FFF, 15'h0);
        send_tick(1'b1, 16'h2000, 16'hE000, 16'h7FFF, 16'h8000);
        send_tick(1'b0, 16'h0, 16'h0, 16'h8000, 16'h7FFF);
        drain();
        program_all(16'hFFFF, 15'h7FFF, 15'h0, 16'h8000, 16'h7FFF, 15'h0, 15'h7FFF);
        send_tick(1'b1, 16'h1000, 16'h1000, 16'h7FFF, 16'h7FFF);
        send_tick(1'b0, 16'h0, 16'h0, 16'h8000, 16'h8000);
        send_tick(1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        drain();
    endtask

    task automatic test_position_saturation;
        program_all(16'hFFFF, 15'h7FFF, 15'h7FFF, 16'h7FFF, 16'h8000, 15'h0, 15'h7FFF);
        send_tick(1'b1, 16'h7FFF, 16'h0, 16'h7FFF, 16'h0);
        repeat (12) send_tick(1'b0, 16'h0, 16'h0, 16'h7FFF, 16'h0);
        send_tick(1'b1, 16'h8000, 16'h0, 16'h8000, 16'h0);
        repeat (12) send_tick(1'b0, 16'h0, 16'h0, 16'h8000, 16'h0);
        drain();
    endtask

    task automatic test_random_settings;
        for (int ph = 0; ph < 8; ph++)
        begin
            program_all(16'($urandom_range(1, 65535)), 15'($urandom_range(0, 32767)),
                        15'($urandom_range(0, 32767)), rand_speed(), rand_speed(),
                        15'($urandom_range(0, 32767)), 15'($urandom_range(0, 32767)));
            random_ticks(140);
            drain();
        end
        program_all(16'd6554, 15'd4096, 15'd4096, 16'd4096, 16'hF800, 15'd4096, 15'd4096);
        random_ticks(80);
        drain();
    endtask

    initial
    begin
        cfg = '{step_time: 16'd6554, accel_limit: 15'd4096, brake_limit: 15'd4096,
                forward_limit: 16'sd4096, backward_limit: -16'sd2048,
                turn_accel_limit: 15'd4096, turn_limit: 15'd4096};
        sp_st = '0;
        tr_st = '0;
        hd_st = '0;
        x_st = '0;
        y_st = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        test_directed_reset_values();
        test_zero_tick_and_crossed_limits();
        test_position_saturation();
        test_random_settings();
        if (!failed)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    always @(negedge clk)
    begin
        if (($time / 20) % 600 < 150)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 2) == 0);
    end

    always @(posedge clk)
    begin
        pose_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pose_q.size() == 0)
            begin
                $display("%0t: unexpected output beat speed=%0d", $time, speed);
                failed = 1'b1;
            end
            else
            begin
                e = pose_q.pop_front();
                if (speed !== e.speed || turn_rate !== e.turn_rate ||
                    pos_x !== e.pos_x || pos_y !== e.pos_y || heading !== e.heading)
                begin
                    $display("%0t: mismatch expected spd=%0d w=%0d x=%0d y=%0d h=%0d",
                             $time, e.speed, e.turn_rate, e.pos_x, e.pos_y, e.heading);
                    $display("%0t:          actual   spd=%0d w=%0d x=%0d y=%0d h=%0d",
                             $time, speed, turn_rate, pos_x, pos_y, heading);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end
endmodule

[sim.f]
src/uvr_pkg.sv
src/uvr_ctrl.sv
src/uvr_datapath.sv
src/unicycle_velocity_rollout_core.sv
sim/tb_unicycle_velocity_rollout_core.sv
